FILE: rtl/char_lcd_nibble_driver_macros.svh
// Assertion helpers shared by the rtl files.
`ifndef CHAR_LCD_NIBBLE_DRIVER_MACROS_SVH
`define CHAR_LCD_NIBBLE_DRIVER_MACROS_SVH

// property that must hold at every clock edge out of reset
`define CLCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// implication checked at the same edge
`define CLCD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

FILE: rtl/clcd_pkg.sv
package clcd_pkg;

	localparam int QUEUE_DEPTH_DEF = 256;

	localparam int OPQ_DEPTH = 4;
	localparam int OPQ_AW    = 2;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

	localparam logic [2:0] ROW_COUNT_RST = 3'd2;
	localparam logic [5:0] COL_COUNT_RST = 6'd16;
	localparam logic [2:0] ROWS_MAX      = 3'd4;

	localparam logic [7:0] CHAR_NL       = 8'h0A;
	localparam logic [7:0] CHAR_CR       = 8'h0D;
	localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

	typedef enum logic [1:0] {
		ACT_TICK       = 2'd0,
		ACT_PUT_CHAR   = 2'd1,
		ACT_SET_CURSOR = 2'd2,
		ACT_RAW_CMD    = 2'd3
	} action_t;

	typedef struct packed {
		logic       rs;
		logic [3:0] nib;
	} nibble_t;

	typedef struct packed {
		nibble_t [3:0] nibs;
		logic [2:0]    cnt;
		logic          pop;
		logic          enable;
		logic          overflow;
	} op_t;

	function automatic logic [7:0] row_offset(input logic [1:0] row);
		logic [7:0] off;
		case (row)
			2'd0:    off = 8'h00;
			2'd1:    off = 8'h40;
			2'd2:    off = 8'h14;
			2'd3:    off = 8'h54;
			default: off = 8'h00;
		endcase
		return off;
	endfunction

	function automatic logic [1:0] clamp_row(input logic [3:0] row, input logic [2:0] rows_cfg);
		logic [2:0] rows;
		logic [1:0] res;
		rows = (rows_cfg > ROWS_MAX) ? ROWS_MAX : rows_cfg;
		res  = ({1'b0, row} >= {2'b00, rows}) ? 2'd0 : row[1:0];
		return res;
	endfunction

	function automatic logic [7:0] set_addr_byte(input logic [1:0] row, input logic [5:0] col);
		logic [7:0] sum;
		sum = {2'b00, col} + row_offset(row);
		return CMD_SET_DDRAM | sum;
	endfunction

endpackage

FILE: rtl/clcd_in_if.sv
interface clcd_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] char_code;
	logic [2:0] row_select;
	logic [5:0] col_select;
	logic [7:0] command_byte;

	modport source (output valid, action, char_code, row_select, col_select, command_byte,
		input ready);
	modport sink (input valid, action, char_code, row_select, col_select, command_byte,
		output ready);
endinterface

FILE: rtl/clcd_out_if.sv
interface clcd_out_if;
	logic       valid;
	logic       ready;
	logic       rs_pin;
	logic [3:0] data_pins;
	logic       enable_pin;
	logic       overflow;

	modport source (output valid, rs_pin, data_pins, enable_pin, overflow, input ready);
	modport sink (input valid, rs_pin, data_pins, enable_pin, overflow, output ready);
endinterface

FILE: rtl/clcd_cfg_if.sv
interface clcd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [clcd_pkg::CFG_IDX_W-1:0]  index;
	logic [clcd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/clcd_front.sv
`include "char_lcd_nibble_driver_macros.svh"

module clcd_front #(
	parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	clcd_in_if.sink           item,
	clcd_cfg_if.sink          cfg,
	output clcd_pkg::op_t     op,
	output logic              op_push,
	input  logic              op_full
);

	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [FW-1:0] DEPTH_V = FW'(QUEUE_DEPTH);

	logic [2:0]    row_count_q;
	logic [5:0]    col_count_q;
	logic [1:0]    cursor_row_q;
	logic [5:0]    cursor_col_q;
	logic [FW-1:0] fill_q;
	logic          en_q;

	clcd_pkg::action_t act;
	clcd_pkg::nibble_t [3:0] nibs;
	logic          wrap;
	logic [1:0]    wrow;
	logic [7:0]    wbyte;
	logic [1:0]    cr;
	logic [5:0]    cc;
	logic [1:0]    r2;
	logic [5:0]    c2;
	logic [7:0]    b2;
	logic          rs2;
	logic [FW-1:0] free;
	logic [2:0]    k;
	logic [2:0]    n;
	logic          pop;
	logic          en_next;
	logic [1:0]    row_next;
	logic [5:0]    col_next;
	logic [FW-1:0] fill_next;
	logic          accept;

	assign item.ready = !op_full;
	assign accept     = item.valid && item.ready;
	assign cfg.ready  = 1'b1;
	assign act        = clcd_pkg::action_t'(item.action);

	assign wrap  = cursor_col_q >= col_count_q;
	assign wrow  = clcd_pkg::clamp_row({2'b00, cursor_row_q} + 4'd1, row_count_q);
	assign wbyte = clcd_pkg::set_addr_byte(wrow, 6'd0);
	assign cr    = wrap ? wrow : cursor_row_q;
	assign cc    = wrap ? 6'd0 : cursor_col_q;
	assign free  = DEPTH_V - fill_q;

	always_comb begin
		r2       = cr;
		c2       = 6'd0;
		b2       = item.command_byte;
		rs2      = 1'b0;
		k        = 3'd2;
		pop      = 1'b0;
		en_next  = en_q;
		row_next = cursor_row_q;
		col_next = cursor_col_q;
		nibs     = '0;
		case (act)
			clcd_pkg::ACT_TICK: begin
				k       = 3'd0;
				pop     = !en_q && (fill_q != '0);
				en_next = en_q ? 1'b0 : (fill_q != '0);
			end
			clcd_pkg::ACT_PUT_CHAR: begin
				if (item.char_code == clcd_pkg::CHAR_NL) begin
					r2 = clcd_pkg::clamp_row({2'b00, cr} + 4'd1, row_count_q);
					b2 = clcd_pkg::set_addr_byte(r2, 6'd0);
				end else if (item.char_code == clcd_pkg::CHAR_CR) begin
					r2 = clcd_pkg::clamp_row({2'b00, cr}, row_count_q);
					b2 = clcd_pkg::set_addr_byte(r2, 6'd0);
				end else begin
					b2  = item.char_code;
					rs2 = 1'b1;
					c2  = cc + 6'd1;
				end
				if (wrap && (free < FW'(2))) begin
					// wrap address lost a nibble: character abandoned
					row_next = wrow;
					col_next = 6'd0;
				end else begin
					row_next = r2;
					col_next = c2;
				end
				if (wrap) begin
					k       = 3'd4;
					nibs[0] = clcd_pkg::nibble_t'({1'b0, wbyte[7:4]});
					nibs[1] = clcd_pkg::nibble_t'({1'b0, wbyte[3:0]});
					nibs[2] = clcd_pkg::nibble_t'({rs2, b2[7:4]});
					nibs[3] = clcd_pkg::nibble_t'({rs2, b2[3:0]});
				end else begin
					nibs[0] = clcd_pkg::nibble_t'({rs2, b2[7:4]});
					nibs[1] = clcd_pkg::nibble_t'({rs2, b2[3:0]});
				end
			end
			clcd_pkg::ACT_SET_CURSOR: begin
				row_next = clcd_pkg::clamp_row({1'b0, item.row_select}, row_count_q);
				col_next = item.col_select;
				b2       = clcd_pkg::set_addr_byte(row_next, item.col_select);
				nibs[0]  = clcd_pkg::nibble_t'({1'b0, b2[7:4]});
				nibs[1]  = clcd_pkg::nibble_t'({1'b0, b2[3:0]});
			end
			default: begin
				nibs[0] = clcd_pkg::nibble_t'({1'b0, item.command_byte[7:4]});
				nibs[1] = clcd_pkg::nibble_t'({1'b0, item.command_byte[3:0]});
			end
		endcase
	end

	assign n         = (free >= FW'(k)) ? k : free[2:0];
	assign fill_next = fill_q + FW'(n) - FW'(pop);

	assign op = '{nibs: nibs, cnt: n, pop: pop, enable: en_next, overflow: FW'(k) > free};
	assign op_push = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= clcd_pkg::ROW_COUNT_RST;
			col_count_q <= clcd_pkg::COL_COUNT_RST;
		end else if (cfg.valid) begin
			if (cfg.index == clcd_pkg::REG_ROW_COUNT) begin
				row_count_q <= cfg.data[2:0];
			end else if (cfg.index == clcd_pkg::REG_COL_COUNT) begin
				col_count_q <= cfg.data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_row_q <= 2'd0;
			cursor_col_q <= 6'd0;
			fill_q       <= '0;
			en_q         <= 1'b0;
		end else if (accept) begin
			cursor_row_q <= row_next;
			cursor_col_q <= col_next;
			fill_q       <= fill_next;
			en_q         <= en_next;
		end
	end

	`CLCD_ASSERT(a_fill_bound, fill_q <= DEPTH_V, "nibble fill count above queue depth")

endmodule

FILE: rtl/clcd_opq.sv
`include "char_lcd_nibble_driver_macros.svh"

module clcd_opq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  clcd_pkg::op_t push_op,
	output logic          full,
	output logic          head_valid,
	output clcd_pkg::op_t head_op,
	input  logic          pop
);

	clcd_pkg::op_t                   ent_q [clcd_pkg::OPQ_DEPTH];
	logic [clcd_pkg::OPQ_AW-1:0]     wr_ptr_q;
	logic [clcd_pkg::OPQ_AW-1:0]     rd_ptr_q;
	logic [clcd_pkg::OPQ_AW:0]       cnt_q;

	assign full       = cnt_q == (clcd_pkg::OPQ_AW + 1)'(clcd_pkg::OPQ_DEPTH);
	assign head_valid = cnt_q != '0;
	assign head_op    = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (clcd_pkg::OPQ_AW + 1)'(push) - (clcd_pkg::OPQ_AW + 1)'(pop);
		end
	end

	`CLCD_ASSERT(a_opq_bound,
		cnt_q <= (clcd_pkg::OPQ_AW + 1)'(clcd_pkg::OPQ_DEPTH), "op queue count above depth")

endmodule

FILE: rtl/clcd_back.sv
`include "char_lcd_nibble_driver_macros.svh"

module clcd_back #(
	parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	input  clcd_pkg::op_t op,
	output logic          op_pop,
	clcd_out_if.source    result
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

	logic [4:0]    mem [QUEUE_DEPTH];
	logic [AW-1:0] tail_q;
	logic [AW-1:0] head_q;
	logic [4:0]    rdata_q;
	logic [2:0]    wr_idx_q;
	logic          rd_pend_q;
	logic [4:0]    pin_q;
	logic          out_valid_q;
	logic          out_rs_q;
	logic [3:0]    out_data_q;
	logic          out_en_q;
	logic          out_ovf_q;

	logic       writes_done;
	logic       done_now;
	logic       wr_en;
	logic       rd_en;
	logic       out_free;
	logic       emit;
	logic [4:0] pin_now;

	assign writes_done = wr_idx_q == op.cnt;
	assign wr_en       = op_valid && !writes_done;
	assign done_now    = writes_done || (wr_en && (wr_idx_q + 3'd1 == op.cnt));
	assign rd_en       = op_valid && writes_done && op.pop && !rd_pend_q;
	assign out_free    = !out_valid_q || result.ready;
	assign emit        = op_valid && done_now && (!op.pop || rd_pend_q) && out_free;
	assign pin_now     = rd_pend_q ? rdata_q : pin_q;
	assign op_pop      = emit;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[tail_q] <= op.nibs[wr_idx_q[1:0]];
		end
		if (rd_en) begin
			rdata_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tail_q      <= '0;
			head_q      <= '0;
			wr_idx_q    <= 3'd0;
			rd_pend_q   <= 1'b0;
			pin_q       <= 5'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				tail_q <= (tail_q == LAST) ? '0 : tail_q + 1'b1;
			end
			if (rd_en) begin
				head_q <= (head_q == LAST) ? '0 : head_q + 1'b1;
			end
			if (emit) begin
				wr_idx_q  <= 3'd0;
				rd_pend_q <= 1'b0;
				pin_q     <= pin_now;
			end else begin
				if (wr_en) begin
					wr_idx_q <= wr_idx_q + 3'd1;
				end
				if (rd_en) begin
					rd_pend_q <= 1'b1;
				end
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_rs_q   <= pin_now[4];
			out_data_q <= pin_now[3:0];
			out_en_q   <= op.enable;
			out_ovf_q  <= op.overflow;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.rs_pin     = out_rs_q;
	assign result.data_pins  = out_data_q;
	assign result.enable_pin = out_en_q;
	assign result.overflow   = out_ovf_q;

	`CLCD_ASSERT_IMPL(a_wr_idx_bound, op_valid, wr_idx_q <= op.cnt,
		"nibble write index past op count")
	`CLCD_ASSERT_IMPL(a_pop_has_data, emit && op.pop, rd_pend_q,
		"strobe beat emitted before its nibble was read")

endmodule

FILE: rtl/char_lcd_nibble_driver.sv
// Character LCD driver for a 4-bit parallel bus.
// item (valid/ready): one beat is a tick, a character, a cursor placement or a
//   raw command byte. cfg (valid/ready, always ready): index 0 row count,
//   index 1 column count; user writes only while the block is idle, unenforced.
// result (valid/ready): exactly one beat per item, in order, giving rs, D7..D4
//   and enable as held after that item, plus the overflow flag of that item.
// The front stage tracks cursor, queue fill and enable level and turns each
// item into an op with up to four nibbles; a four-entry op queue feeds the back
// stage, which owns the QUEUE_DEPTH-entry nibble memory and the pin latch.
// Throughput is set by the single memory write port, which writes the nibbles
// of an op in turn: a character that wraps or a newline at wrap has four, a
// plain character, cursor or command two, fewer when nibbles are dropped; a
// tick has none; one that strobes a nibble first does a registered memory read.
// Reset clears cursor, queue pointers, pins and config (2 rows, 16 columns);
// nibble memory contents are not cleared and need no clearing pass.
// A stalled result holds its beat; the op queue keeps taking items until full,
// then item.ready drops.
module char_lcd_nibble_driver #(
	parameter int QUEUE_DEPTH = clcd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	clcd_in_if.sink    item,
	clcd_cfg_if.sink   cfg,
	clcd_out_if.source result
);

	clcd_pkg::op_t front_op;
	clcd_pkg::op_t head_op;
	logic          op_push;
	logic          op_full;
	logic          head_valid;
	logic          op_pop;

	clcd_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cfg     (cfg),
		.op      (front_op),
		.op_push (op_push),
		.op_full (op_full)
	);

	clcd_opq u_opq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (op_push),
		.push_op    (front_op),
		.full       (op_full),
		.head_valid (head_valid),
		.head_op    (head_op),
		.pop        (op_pop)
	);

	clcd_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.op_valid (head_valid),
		.op       (head_op),
		.op_pop   (op_pop),
		.result   (result)
	);

endmodule
